FILE: hdl/charlieplex_segment_display_driver_macros.svh
// assertion macros for the charlieplexed display driver
// no dependencies; included by files that carry concurrent checks
`ifndef CHARLIEPLEX_SEGMENT_DISPLAY_DRIVER_MACROS_SVH
`define CHARLIEPLEX_SEGMENT_DISPLAY_DRIVER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define CSDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CSDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CSDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/csdd_pkg.sv
// shared codes, types and digit helpers for the charlieplexed display driver
// no dependencies; imported by every module of the block
package csdd_pkg;

  // word kinds
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // number formats
  localparam logic [1:0] FMT_DIGITS = 2'd0;
  localparam logic [1:0] FMT_CLOCK  = 2'd1;
  localparam logic [1:0] FMT_BLANK  = 2'd2;

  // status kinds
  localparam logic [2:0] KIND_BATTERY = 3'd0;
  localparam logic [2:0] KIND_TIMER   = 3'd1;
  localparam logic [2:0] KIND_COUNT   = 3'd2;
  localparam logic [2:0] KIND_FREE    = 3'd3;
  localparam logic [2:0] KIND_LINK    = 3'd4;

  // icon masks
  localparam logic [7:0] ICON_BATT_KEEP = 8'hD3;
  localparam logic [7:0] ICON_MODE_KEEP = 8'hEC;
  localparam logic [7:0] ICON_LINK_KEEP = 8'hBF;
  localparam logic [7:0] ICON_LINK_SET  = 8'h40;
  localparam logic [7:0] ICON_TIMER_SET = 8'h11;
  localparam logic [7:0] ICON_COUNT_SET = 8'h02;
  localparam logic [7:0] ICON_BATT_1    = 8'h08;
  localparam logic [7:0] ICON_BATT_2    = 8'h0C;
  localparam logic [7:0] ICON_BATT_3    = 8'h2C;

  // segment bit positions
  localparam int unsigned SEG_A = 0;
  localparam int unsigned SEG_B = 1;
  localparam int unsigned SEG_C = 2;
  localparam int unsigned SEG_D = 3;
  localparam int unsigned SEG_E = 4;
  localparam int unsigned SEG_F = 5;
  localparam int unsigned SEG_G = 6;

  localparam logic [2:0] BLANK_PHASE = 3'd7;

  typedef logic [6:0] seg_t;

  // decoded word plus its constant quotients, passed to the state stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] value;
    logic [1:0]  fmt;
    logic [2:0]  kind;
    logic [1:0]  arg;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
    logic [10:0] q60;
    logic [6:0]  q600;
  } split_t;

  // decimal digit to segments
  function automatic seg_t glyph(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // remainder by ten of a value below 128
  function automatic logic [3:0] mod10_7(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd80) r = r - 7'd80;
    if (r >= 7'd40) r = r - 7'd40;
    if (r >= 7'd20) r = r - 7'd20;
    if (r >= 7'd10) r = r - 7'd10;
    return r[3:0];
  endfunction

  // tens digit of a seconds count below 64
  function automatic logic [2:0] tens_6(input logic [5:0] s);
    logic [2:0] t;
    if (s >= 6'd60)      t = 3'd6;
    else if (s >= 6'd50) t = 3'd5;
    else if (s >= 6'd40) t = 3'd4;
    else if (s >= 6'd30) t = 3'd3;
    else if (s >= 6'd20) t = 3'd2;
    else if (s >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [15:0] times10(input logic [15:0] x);
    return {x[12:0], 3'b000} + {x[14:0], 1'b0};
  endfunction

  function automatic logic [15:0] times60(input logic [15:0] x);
    return {x[9:0], 6'b000000} - {x[13:0], 2'b00};
  endfunction

endpackage

FILE: hdl/csdd_split.sv
// input register and constant-quotient stage
// depends on csdd_pkg; quotients by reciprocal multiplication, exact for 16-bit values
module csdd_split import csdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic        in_valid_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  number_format_i,
  input  logic [2:0]  status_kind_i,
  input  logic [1:0]  status_arg_i,
  output logic        split_valid_o,
  output split_t      split_o
);

  logic        s1_valid_q;
  logic [1:0]  s1_mode_q;
  logic [15:0] s1_value_q;
  logic [1:0]  s1_fmt_q;
  logic [2:0]  s1_kind_q;
  logic [1:0]  s1_arg_q;

  logic        s2_valid_q;
  split_t      s2_q;
  split_t      s2_d;

  logic [32:0] p10, p100, p1000, p60, p600;

  // valid bits of the input word and quotient stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_mode_q  <= mode_i;
      s1_value_q <= value_i;
      s1_fmt_q   <= number_format_i;
      s1_kind_q  <= status_kind_i;
      s1_arg_q   <= status_arg_i;
      s2_q       <= s2_d;
    end
  end

  // reciprocal products
  assign p10   = 33'(s1_value_q) * 33'(17'd52429);
  assign p100  = 33'(s1_value_q) * 33'(17'd83887);
  assign p1000 = 33'(s1_value_q) * 33'(17'd67109);
  assign p60   = 33'(s1_value_q) * 33'(17'd69906);
  assign p600  = 33'(s1_value_q) * 33'(17'd111849);

  always_comb begin
    s2_d.mode  = s1_mode_q;
    s2_d.value = s1_value_q;
    s2_d.fmt   = s1_fmt_q;
    s2_d.kind  = s1_kind_q;
    s2_d.arg   = s1_arg_q;
    s2_d.q10   = p10[31:19];
    s2_d.q100  = p100[32:23];
    s2_d.q1000 = p1000[32:26];
    s2_d.q60   = p60[32:22];
    s2_d.q600  = p600[32:26];
  end

  assign split_valid_o = s2_valid_q;
  assign split_o       = s2_q;

endmodule

FILE: hdl/csdd_store.sv
// digit and icon state with number and status write handling
// depends on csdd_pkg; fed by csdd_split
module csdd_store import csdd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         update_i,
  input  split_t       item_i,
  output seg_t [3:0]   digits_o,
  output logic [7:0]   icons_o
);

  seg_t [3:0]  digits_q, digits_d;
  logic [7:0]  icons_q, icons_d;
  seg_t [3:0]  plain_segs, clock_segs;

  logic [15:0] units_w, tens_w, hund_w, mins_w, secs_w;
  logic [5:0]  secs;
  logic [2:0]  sec_tens;
  logic [5:0]  sec_units;

  // plain four-digit conversion with leading-zero blanking
  always_comb begin
    units_w = item_i.value - times10(16'(item_i.q10));
    tens_w  = 16'(item_i.q10) - times10(16'(item_i.q100));
    hund_w  = 16'(item_i.q100) - times10(16'(item_i.q1000));
    plain_segs[0] = (item_i.q1000 == 7'd0) ? 7'h00 : glyph(mod10_7(item_i.q1000));
    plain_segs[1] = (item_i.q100 == 10'd0) ? 7'h00 : glyph(hund_w[3:0]);
    plain_segs[2] = (item_i.q10 == 13'd0)  ? 7'h00 : glyph(tens_w[3:0]);
    plain_segs[3] = glyph(units_w[3:0]);
  end

  // minutes:seconds conversion
  always_comb begin
    mins_w    = 16'(item_i.q60) - times10(16'(item_i.q600));
    secs_w    = item_i.value - times60(16'(item_i.q60));
    secs      = secs_w[5:0];
    sec_tens  = tens_6(secs);
    sec_units = secs - (6'(sec_tens) << 3) - (6'(sec_tens) << 1);
    clock_segs[0] = (item_i.q600 == 7'd0) ? 7'h00 : glyph(mod10_7(item_i.q600));
    clock_segs[1] = (item_i.q60 == 11'd0) ? 7'h00 : glyph(mins_w[3:0]);
    clock_segs[2] = glyph({1'b0, sec_tens});
    clock_segs[3] = glyph(sec_units[3:0]);
  end

  // next state from the word at the head of the pipe
  always_comb begin
    digits_d = digits_q;
    icons_d  = icons_q;
    if (update_i) begin
      if (item_i.mode == MODE_NUMBER) begin
        case (item_i.fmt)
          FMT_BLANK: begin
            digits_d = '0;
            icons_d  = 8'h00;
          end
          FMT_CLOCK: digits_d = clock_segs;
          default:   digits_d = plain_segs;
        endcase
      end else if (item_i.mode == MODE_STATUS) begin
        unique case (item_i.kind)
          KIND_BATTERY: begin
            case (item_i.arg)
              2'd1:    icons_d = (icons_q & ICON_BATT_KEEP) | ICON_BATT_1;
              2'd2:    icons_d = (icons_q & ICON_BATT_KEEP) | ICON_BATT_2;
              2'd3:    icons_d = (icons_q & ICON_BATT_KEEP) | ICON_BATT_3;
              default: icons_d = icons_q & ICON_BATT_KEEP;
            endcase
          end
          KIND_TIMER: icons_d = (icons_q & ICON_MODE_KEEP) | ICON_TIMER_SET;
          KIND_COUNT: icons_d = (icons_q & ICON_MODE_KEEP) | ICON_COUNT_SET;
          KIND_FREE:  icons_d = icons_q & ICON_MODE_KEEP;
          KIND_LINK: begin
            if (item_i.arg != 2'd0) icons_d = icons_q | ICON_LINK_SET;
            else                    icons_d = icons_q & ICON_LINK_KEEP;
          end
          default: icons_d = icons_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      icons_q  <= 8'h00;
    end else begin
      digits_q <= digits_d;
      icons_q  <= icons_d;
    end
  end

  assign digits_o = digits_q;
  assign icons_o  = icons_q;

endmodule

FILE: hdl/charlieplex_segment_display_driver.sv
// a word passes the input register, the quotient stage and the result register in turn;
// only scan ticks produce a result
// throughput: one word per cycle; the pipe only halts while a result waits on out_ready_i
// writes update the display state when they reach the third stage, in word order
// reset clears the scan phase, all four digits and the icon byte, and empties the pipe
// depends on csdd_pkg, csdd_split, csdd_store and the assertion macro header
`include "charlieplex_segment_display_driver_macros.svh"

module charlieplex_segment_display_driver import csdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  number_format_i,
  input  logic [2:0]  status_kind_i,
  input  logic [1:0]  status_arg_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  pin_enable_o,
  output logic [6:0]  pin_level_o,
  output logic [6:0]  pin_strong_o,
  output logic [2:0]  phase_o
);

  logic        advance;
  logic        split_valid;
  split_t      split_item;
  logic        update;
  logic        tick_fire;
  seg_t [3:0]  digits;
  logic [7:0]  icons;

  logic        out_valid_q;
  logic [2:0]  scan_phase_q;
  logic [6:0]  enable_q, level_q, strong_q;
  logic [2:0]  phase_q;
  logic [6:0]  enable_d, common_d;

  // cathode pins pulled low in each phase, per the fixed wiring
  function automatic logic [6:0] lit_pins(input logic [2:0] ph, input seg_t [3:0] d,
                                          input logic [7:0] ic);
    logic [6:0] p;
    p = 7'h00;
    unique case (ph)
      3'd0: begin
        p[1] = d[0][SEG_A]; p[2] = d[0][SEG_B]; p[3] = d[0][SEG_E];
        p[4] = ic[3];       p[5] = ic[5];
      end
      3'd1: begin
        p[0] = d[0][SEG_F]; p[2] = d[1][SEG_A]; p[3] = d[1][SEG_B];
        p[5] = d[1][SEG_D]; p[4] = d[1][SEG_E];
      end
      3'd2: begin
        p[0] = d[0][SEG_G]; p[1] = d[1][SEG_F]; p[4] = d[2][SEG_B];
        p[5] = ic[0];       p[6] = ic[6];       p[3] = ic[4];
      end
      3'd3: begin
        p[0] = d[0][SEG_C]; p[1] = d[1][SEG_G]; p[4] = d[2][SEG_C];
        p[2] = d[2][SEG_F]; p[5] = d[3][SEG_E];
      end
      3'd4: begin
        p[0] = d[0][SEG_D]; p[1] = d[1][SEG_C]; p[3] = d[2][SEG_A];
        p[2] = d[2][SEG_G]; p[5] = d[3][SEG_C]; p[6] = d[3][SEG_G];
      end
      3'd5: begin
        p[0] = d[2][SEG_D]; p[2] = d[2][SEG_E]; p[6] = d[3][SEG_B];
        p[3] = d[3][SEG_D]; p[4] = d[3][SEG_F]; p[1] = ic[2];
      end
      3'd6: begin
        p[5] = d[3][SEG_A]; p[2] = ic[1]; p[1] = ic[7];
      end
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  // whole pipe moves unless a result is held
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  csdd_split u_split (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .in_valid_i      (in_valid_i),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .number_format_i (number_format_i),
    .status_kind_i   (status_kind_i),
    .status_arg_i    (status_arg_i),
    .split_valid_o   (split_valid),
    .split_o         (split_item)
  );

  assign update    = advance && split_valid;
  assign tick_fire = update && (split_item.mode == MODE_TICK);

  csdd_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (update),
    .item_i   (split_item),
    .digits_o (digits),
    .icons_o  (icons)
  );

  // pin masks for the current phase
  always_comb begin
    if (scan_phase_q == BLANK_PHASE) begin
      common_d = 7'h00;
      enable_d = 7'h00;
    end else begin
      common_d = 7'(8'd1 << scan_phase_q);
      enable_d = common_d | lit_pins(scan_phase_q, digits, icons);
    end
  end

  // result register and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      scan_phase_q <= 3'd0;
    end else begin
      if (advance) out_valid_q <= tick_fire;
      if (tick_fire) scan_phase_q <= scan_phase_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      enable_q <= enable_d;
      level_q  <= common_d;
      strong_q <= common_d;
      phase_q  <= scan_phase_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pin_enable_o = enable_q;
  assign pin_level_o  = level_q;
  assign pin_strong_o = strong_q;
  assign phase_o      = phase_q;

  // checks
  `CSDD_ASSERT_NOW(a_blank_dark, clk_i, rst_ni,
    out_valid_o && (phase_o == BLANK_PHASE),
    (pin_enable_o == 7'h00) && (pin_level_o == 7'h00) && (pin_strong_o == 7'h00),
    "blank phase drives a pin")
  `CSDD_ASSERT_NOW(a_one_common, clk_i, rst_ni,
    out_valid_o && (phase_o != BLANK_PHASE),
    $onehot(pin_strong_o) && (pin_level_o == pin_strong_o)
      && ((pin_enable_o & pin_strong_o) == pin_strong_o),
    "scan phase without exactly one driven common pin")
  `CSDD_ASSERT_NEXT(a_phase_step, clk_i, rst_ni,
    tick_fire, scan_phase_q == 3'($past(scan_phase_q) + 3'd1),
    "scan phase did not advance on a tick")
  `CSDD_ASSERT_NEXT(a_write_silent, clk_i, rst_ni,
    update && (split_item.mode != MODE_TICK), !out_valid_o,
    "write produced a result")

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the charlieplexed four-digit display driver
// depends on csdd_pkg and the charlieplex_segment_display_driver top level
// words are queued up front, driven at the falling edge and checked against an in-bench model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csdd_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] FMT_SPARE  = 2'd3;
  localparam logic [2:0] KIND_SPARE = 3'd5;
  localparam int unsigned MAX_IDLE     = 17;
  localparam int unsigned RANDOM_WORDS = 1600;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] value;
    logic [1:0]  fmt;
    logic [2:0]  kind;
    logic [1:0]  arg;
    int unsigned gap;
    bit          drain_first;
  } word_t;

  typedef struct packed {
    logic [6:0] enable;
    logic [6:0] level;
    logic [6:0] drive;
    logic [2:0] phase;
  } pin_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_TICK;
  logic [15:0] value_i = '0;
  logic [1:0]  number_format_i = FMT_DIGITS;
  logic [2:0]  status_kind_i = KIND_BATTERY;
  logic [1:0]  status_arg_i = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [6:0]  pin_enable_o;
  logic [6:0]  pin_level_o;
  logic [6:0]  pin_strong_o;
  logic [2:0]  phase_o;

  charlieplex_segment_display_driver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .number_format_i (number_format_i),
    .status_kind_i   (status_kind_i),
    .status_arg_i    (status_arg_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .pin_enable_o    (pin_enable_o),
    .pin_level_o     (pin_level_o),
    .pin_strong_o    (pin_strong_o),
    .phase_o         (phase_o)
  );

  // words still to send and pin frames still to arrive
  word_t      pending_words[$];
  pin_frame_t pending_frames[$];
  int unsigned fail_count = 0;

  // model of the display state
  logic [2:0] scan_phase_q = '0;
  logic [6:0] digit_segs_q [4] = '{default: '0};
  logic [7:0] icon_bits_q = '0;

  // handshake bookkeeping between the rising and falling edge blocks
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  bit          have_next = 1'b0;
  word_t       next_word;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_cap = MAX_IDLE;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // decimal digit to segments a..g
  function automatic logic [6:0] digit_glyph(input int unsigned d);
    case (d)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      9: return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // pins pulled low by lit segments and icons in one scan phase
  function automatic logic [6:0] lit_pins(input logic [2:0] ph);
    logic [6:0] p;
    logic [6:0] d0, d1, d2, d3;
    logic [7:0] ic;
    p  = '0;
    d0 = digit_segs_q[0];
    d1 = digit_segs_q[1];
    d2 = digit_segs_q[2];
    d3 = digit_segs_q[3];
    ic = icon_bits_q;
    case (ph)
      3'd0: begin
        p[1] = d0[SEG_A]; p[2] = d0[SEG_B]; p[3] = d0[SEG_E];
        p[4] = ic[3];     p[5] = ic[5];
      end
      3'd1: begin
        p[0] = d0[SEG_F]; p[2] = d1[SEG_A]; p[3] = d1[SEG_B];
        p[5] = d1[SEG_D]; p[4] = d1[SEG_E];
      end
      3'd2: begin
        p[0] = d0[SEG_G]; p[1] = d1[SEG_F]; p[4] = d2[SEG_B];
        p[5] = ic[0];     p[6] = ic[6];     p[3] = ic[4];
      end
      3'd3: begin
        p[0] = d0[SEG_C]; p[1] = d1[SEG_G]; p[4] = d2[SEG_C];
        p[2] = d2[SEG_F]; p[5] = d3[SEG_E];
      end
      3'd4: begin
        p[0] = d0[SEG_D]; p[1] = d1[SEG_C]; p[3] = d2[SEG_A];
        p[2] = d2[SEG_G]; p[5] = d3[SEG_C]; p[6] = d3[SEG_G];
      end
      3'd5: begin
        p[0] = d2[SEG_D]; p[2] = d2[SEG_E]; p[6] = d3[SEG_B];
        p[3] = d3[SEG_D]; p[4] = d3[SEG_F]; p[1] = ic[2];
      end
      3'd6: begin
        p[5] = d3[SEG_A]; p[2] = ic[1];     p[1] = ic[7];
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  // apply one accepted word to the model, queue a frame for scan ticks
  task automatic advance_display(input word_t w);
    int unsigned v, mins, secs;
    pin_frame_t f;
    logic [6:0] common;
    v = w.value;
    case (w.mode)
      MODE_NUMBER: begin
        if (w.fmt == FMT_BLANK) begin
          digit_segs_q = '{default: '0};
          icon_bits_q  = '0;
        end else if (w.fmt == FMT_CLOCK) begin
          mins = v / 60;
          secs = v % 60;
          digit_segs_q[0] = (mins < 10) ? 7'h00 : digit_glyph((mins / 10) % 10);
          digit_segs_q[1] = (mins == 0) ? 7'h00 : digit_glyph(mins % 10);
          digit_segs_q[2] = digit_glyph(secs / 10);
          digit_segs_q[3] = digit_glyph(secs % 10);
        end else begin
          digit_segs_q[0] = (v < 1000) ? 7'h00 : digit_glyph((v / 1000) % 10);
          digit_segs_q[1] = (v < 100) ? 7'h00 : digit_glyph((v / 100) % 10);
          digit_segs_q[2] = (v < 10) ? 7'h00 : digit_glyph((v / 10) % 10);
          digit_segs_q[3] = digit_glyph(v % 10);
        end
      end
      MODE_STATUS: begin
        case (w.kind)
          KIND_BATTERY: begin
            icon_bits_q = icon_bits_q & ICON_BATT_KEEP;
            case (w.arg)
              2'd1:    icon_bits_q = icon_bits_q | ICON_BATT_1;
              2'd2:    icon_bits_q = icon_bits_q | ICON_BATT_2;
              2'd3:    icon_bits_q = icon_bits_q | ICON_BATT_3;
              default: ;
            endcase
          end
          KIND_TIMER: icon_bits_q = (icon_bits_q & ICON_MODE_KEEP) | ICON_TIMER_SET;
          KIND_COUNT: icon_bits_q = (icon_bits_q & ICON_MODE_KEEP) | ICON_COUNT_SET;
          KIND_FREE:  icon_bits_q = icon_bits_q & ICON_MODE_KEEP;
          KIND_LINK: begin
            if (w.arg != 2'd0) icon_bits_q = icon_bits_q | ICON_LINK_SET;
            else               icon_bits_q = icon_bits_q & ICON_LINK_KEEP;
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        f = '0;
        f.phase = scan_phase_q;
        if (scan_phase_q != BLANK_PHASE) begin
          common   = 7'd1 << scan_phase_q;
          f.enable = common | lit_pins(scan_phase_q);
          f.level  = common;
          f.drive  = common;
        end
        pending_frames.push_back(f);
        scan_phase_q = scan_phase_q + 3'd1;
      end
      default: ;
    endcase
  endtask

  // check outgoing frames, then feed accepted words to the model
  always @(posedge clk_i) begin
    pin_frame_t want;
    word_t      w;
    in_taken  <= in_valid && in_ready_o;
    out_taken <= out_valid_o && out_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected frame en=%h lvl=%h str=%h ph=%0d", $time,
                   pin_enable_o, pin_level_o, pin_strong_o, phase_o);
          fail_count++;
        end else begin
          want = pending_frames.pop_front();
          if (pin_enable_o !== want.enable) begin
            $display("%0t: pin_enable expected %h got %h", $time, want.enable, pin_enable_o);
            fail_count++;
          end
          if (pin_level_o !== want.level) begin
            $display("%0t: pin_level expected %h got %h", $time, want.level, pin_level_o);
            fail_count++;
          end
          if (pin_strong_o !== want.drive) begin
            $display("%0t: pin_strong expected %h got %h", $time, want.drive, pin_strong_o);
            fail_count++;
          end
          if (phase_o !== want.phase) begin
            $display("%0t: phase expected %0d got %0d", $time, want.phase, phase_o);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        w.mode  = mode_i;
        w.value = value_i;
        w.fmt   = number_format_i;
        w.kind  = status_kind_i;
        w.arg   = status_arg_i;
        w.gap   = 0;
        w.drain_first = 1'b0;
        advance_display(w);
      end
    end
  end

  // word driver: gap before each word, optional drain, hold until taken
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_ni) begin
      if (in_valid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (!have_next && pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          have_next = 1'b1;
          gap_left  = next_word.gap;
        end
        if (have_next) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!next_word.drain_first || pending_frames.size() == 0) begin
            mode_i          <= next_word.mode;
            value_i         <= next_word.value;
            number_format_i <= next_word.fmt;
            status_kind_i   <= next_word.kind;
            status_arg_i    <= next_word.arg;
            nxt_valid = 1'b1;
            have_next = 1'b0;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // frame receiver: random stall after each frame, quiet stretches now and then
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 63) == 0) stall_cap = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
        stall_left = $urandom_range(0, stall_cap);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic queue_word(input logic [1:0] mode, input logic [15:0] value,
                            input logic [1:0] fmt, input logic [2:0] kind,
                            input logic [1:0] arg, input int unsigned gap,
                            input bit drain_first);
    word_t w;
    w.mode  = mode;
    w.value = value;
    w.fmt   = fmt;
    w.kind  = kind;
    w.arg   = arg;
    w.gap   = gap;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 6))
      0:       return 16'($urandom_range(0, 12));
      1:       return 16'($urandom_range(90, 110));
      2:       return 16'($urandom_range(990, 1010));
      3:       return 16'($urandom_range(0, 3600));
      4:       return 16'($urandom_range(0, 700));
      5:       return 16'($urandom_range(0, 9999));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus: reset, directed words, then random words
  initial begin
    int unsigned useful, pick, gap;
    logic [1:0] mode, fmt;
    logic [2:0] kind;
    bit calm;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // dark display, unused mode, digit and clock extremes, every status kind
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_SPARE,  16'hFFFF,  FMT_SPARE,  3'd7,         2'd3, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'hFFFF,  FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd999,   FMT_DIGITS, KIND_BATTERY, 2'd0, 2, 1'b0);
    queue_word(MODE_NUMBER, 16'd1000,  FMT_SPARE,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd0,     FMT_CLOCK,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd599,   FMT_CLOCK,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd600,   FMT_CLOCK,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'hFFFF,  FMT_CLOCK,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd1, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd2, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd3, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_TIMER,   2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_COUNT,   2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_LINK,    2'd1, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_FREE,    2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_LINK,    2'd0, 0, 1'b0);
    queue_word(MODE_STATUS, 16'd0,     FMT_DIGITS, KIND_SPARE,   2'd3, 0, 1'b0);
    queue_word(MODE_NUMBER, 16'd0,     FMT_BLANK,  KIND_BATTERY, 2'd0, 0, 1'b0);
    queue_word(MODE_TICK,   16'd0,     FMT_DIGITS, KIND_BATTERY, 2'd0, 0, 1'b1);

    // random words, mostly ticks so every write gets scanned out
    useful = 0;
    calm   = 1'b0;
    while (useful < RANDOM_WORDS) begin
      if ($urandom_range(0, 79) == 0) calm = ~calm;
      gap  = calm ? 0 : $urandom_range(0, MAX_IDLE);
      pick = $urandom_range(0, 99);
      if (pick < 64)      mode = MODE_TICK;
      else if (pick < 81) mode = MODE_NUMBER;
      else if (pick < 97) mode = MODE_STATUS;
      else                mode = MODE_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 45)      fmt = FMT_DIGITS;
      else if (pick < 85) fmt = FMT_CLOCK;
      else if (pick < 93) fmt = FMT_BLANK;
      else                fmt = FMT_SPARE;
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      queue_word(mode, random_value(), fmt, kind, 2'($urandom_range(0, 3)), gap,
                 $urandom_range(0, 149) == 0);
      if (mode != MODE_SPARE && !(mode == MODE_STATUS && kind > KIND_LINK)) useful++;
    end

    // let everything drain, then a short tail for stray frames
    while (pending_words.size() != 0 || have_next || in_valid) @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_frames.size() != 0) begin
      $display("%0t: %0d frames never arrived", $time, pending_frames.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
